// ===== rtl/sync_length_header_framer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the framer's parser, slhf_parse.
// Each macro expects signals named clk and arst_n in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_HEADER_FRAMER_UNIT_ASSERT_SVH
`define SYNC_LENGTH_HEADER_FRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLHF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLHF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/slhf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slhf_pkg
// Types, register indexes and reset constants of the sync/length framer.
// ---------------------------------------------------------------------------
package slhf_pkg;

	// Register indexes on the configuration port (byte address 4 * index).
	localparam logic REG_SYNC  = 1'b0;
	localparam logic REG_IDENT = 1'b1;

	// Register reset values.
	localparam logic [7:0]  SYNC_RESET  = 8'hAA;
	localparam logic [10:0] IDENT_RESET = 11'h636;

	// Header bytes held before the final header byte arrives.
	localparam logic [2:0] STORE_DEPTH = 3'd5;

	// Frame parser modes.
	typedef enum logic [1:0] {
		MODE_HUNT    = 2'd0,
		MODE_COLLECT = 2'd1,
		MODE_DISCARD = 2'd2
	} mode_t;

	// Configuration register contents.
	typedef struct packed {
		logic [7:0]  sync_value;
		logic [10:0] frame_ident;
	} cfg_t;

	// One decoded frame header.
	typedef struct packed {
		logic [63:0] payload;
		logic [10:0] ident_out;
		logic [7:0]  sequence_res;
		logic [15:0] length_field;
		logic [15:0] opcode_field;
		logic [15:0] skip_count;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/slhf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slhf_cfg
// APB-style register bank holding the sync byte and the frame identifier.
// ---------------------------------------------------------------------------
module slhf_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output slhf_pkg::cfg_t    cfg
);
	import slhf_pkg::*;

	logic [7:0]  sync_value_q;
	logic [10:0] frame_ident_q;
	logic        wr_en;
	logic        reg_idx;

	// A write transaction completes in its access phase; the port never stalls.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	// Register update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q  <= SYNC_RESET;
			frame_ident_q <= IDENT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC:  sync_value_q  <= pwdata[7:0];
				REG_IDENT: frame_ident_q <= pwdata[10:0];
				default:   ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (reg_idx)
			REG_SYNC:  prdata = {24'h000000, sync_value_q};
			REG_IDENT: prdata = {21'h000000, frame_ident_q};
			default:   prdata = 32'h00000000;
		endcase
	end

	assign cfg.sync_value  = sync_value_q;
	assign cfg.frame_ident = frame_ident_q;

endmodule
`default_nettype wire

// ===== rtl/slhf_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sync_length_header_framer_unit_assert.svh"
// ---------------------------------------------------------------------------
// slhf_parse
// Input register and frame parser: hunts for sync, gathers the header,
// decodes it and counts off the trailing bytes.
// ---------------------------------------------------------------------------
module slhf_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire slhf_pkg::cfg_t  cfg,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            out_free,
	output logic                 res_load,
	output slhf_pkg::result_t    res
);
	import slhf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	mode_t       mode_q, mode_d;
	logic [2:0]  count_q, count_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  store_q [STORE_DEPTH];

	logic        emit;
	logic        store_we;
	logic [2:0]  store_idx;
	logic [15:0] len;
	logic [15:0] skip_dec;

	// The final header byte needs room in the result register; all
	// other bytes move on unconditionally.
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;
	assign res_load = advance && emit;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign len      = {store_q[3], store_q[2]};
	assign skip_dec = (skip_q != 16'h0000) ? skip_q - 16'h0001 : 16'h0000;

	// Next state.
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		skip_d  = skip_q;
		case (mode_q)
			MODE_COLLECT: begin
				if (count_q < STORE_DEPTH) begin
					count_d = count_q + 3'd1;
				end else begin
					count_d = 3'd0;
					skip_d  = res.skip_count;
					mode_d  = (res.skip_count != 16'h0000) ? MODE_DISCARD : MODE_HUNT;
				end
			end
			MODE_DISCARD: begin
				skip_d = skip_dec;
				if (skip_dec == 16'h0000) begin
					mode_d = MODE_HUNT;
				end
			end
			default: begin
				// Hunting, and the unused mode code, which behaves as hunting.
				mode_d = MODE_HUNT;
				if (byte_s1 == cfg.sync_value) begin
					count_d = 3'd1;
					mode_d  = MODE_COLLECT;
				end
			end
		endcase
	end

	// Outputs: header store write and the decoded result.
	always_comb begin
		emit      = 1'b0;
		store_we  = 1'b0;
		store_idx = count_q;
		case (mode_q)
			MODE_COLLECT: begin
				if (count_q < STORE_DEPTH) begin
					store_we = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			MODE_DISCARD: begin
				store_we = 1'b0;
			end
			default: begin
				store_idx = 3'd0;
				store_we  = (byte_s1 == cfg.sync_value);
			end
		endcase

		res.payload      = {16'h0000, byte_s1, store_q[4], store_q[3], store_q[2],
		                    store_q[1], store_q[0]};
		res.ident_out    = cfg.frame_ident;
		res.sequence_res = store_q[1];
		res.length_field = len;
		res.opcode_field = {byte_s1, store_q[4]};
		res.skip_count   = (len >= 16'd2) ? len - 16'd2 : 16'h0000;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			count_q <= 3'd0;
			skip_q  <= 16'h0000;
		end else if (advance) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			skip_q  <= skip_d;
		end
	end

	// Header store; each entry is written before the frame reads it.
	always_ff @(posedge clk) begin
		if (advance && store_we) begin
			store_q[store_idx] <= byte_s1;
		end
	end

	`SLHF_ASSERT_SAME(a_discard_has_work, mode_q == MODE_DISCARD, skip_q != 16'h0000,
		"discard mode with nothing left to skip")
	`SLHF_ASSERT_SAME(a_collect_count, mode_q == MODE_COLLECT, count_q != 3'd0,
		"collecting with an empty header count")
	`SLHF_ASSERT_NEXT(a_emit_clears_count, res_load, count_q == 3'd0,
		"header count not cleared after a frame")
	`SLHF_ASSERT_NEXT(a_short_frame_hunts, res_load && (res.skip_count == 16'h0000),
		mode_q == MODE_HUNT, "frame without trailer did not return to hunting")

endmodule
`default_nettype wire

// ===== rtl/slhf_outreg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// slhf_outreg
// Result register holding one decoded frame until the consumer takes it.
// ---------------------------------------------------------------------------
module slhf_outreg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_load,
	input  wire slhf_pkg::result_t  res,
	output logic                    out_free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output slhf_pkg::result_t       res_out
);
	import slhf_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Free when empty or being emptied in this cycle.
	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sync_length_header_framer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timing: a byte is registered on acceptance and decoded in the next cycle; the result
// of a final header byte goes from the input register through the result register to out_valid.
// Throughput: one byte per cycle, set by the combinational parser between the input
// register and the result register; a waiting result stalls only a final header byte.
// Reset: arst_n clears all control state at once; registers return to sync 0xAA, ident 0x636.
// ---------------------------------------------------------------------------
// sync_length_header_framer_unit
// Byte-stream framer that finds a sync byte, decodes a six-byte header and
// skips the frame trailer.
// ---------------------------------------------------------------------------
module sync_length_header_framer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Byte input channel.
	input  wire logic [7:0]  rx_byte,
	input  wire logic        in_valid,
	output logic             in_ready,
	// Result channel.
	output logic [63:0]      payload,
	output logic [10:0]      ident_out,
	output logic [7:0]       sequence_res,
	output logic [15:0]      length_field,
	output logic [15:0]      opcode_field,
	output logic [15:0]      skip_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import slhf_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_out;
	logic    res_load;
	logic    out_free;

	// Register bank.
	slhf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Parser.
	slhf_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.rx_byte  (rx_byte),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res)
	);

	// Result register.
	slhf_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_out   (res_out)
	);

	assign payload      = res_out.payload;
	assign ident_out    = res_out.ident_out;
	assign sequence_res = res_out.sequence_res;
	assign length_field = res_out.length_field;
	assign opcode_field = res_out.opcode_field;
	assign skip_count   = res_out.skip_count;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length header framer. A scoreboard class
// predicts each decoded header from the accepted byte stream and checks the
// result channel in order. Stimulus runs through directed frames, then phases
// of random frames under several register settings, with back-pressure.
// ---------------------------------------------------------------------------
module tb_top;
	import slhf_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_FRAMES = 4;

	// Predicts decoded headers from accepted bytes and checks the results.
	class frame_header_scoreboard;
		logic [7:0]  sync_pattern;
		logic [10:0] ident;
		mode_t       mode;
		logic [7:0]  hdr [STORE_DEPTH];
		int unsigned hdr_count;
		logic [15:0] skip_left;
		result_t     frames_due [$];
		int unsigned errors;

		function new();
			sync_pattern = SYNC_RESET;
			ident        = IDENT_RESET;
			mode         = MODE_HUNT;
			hdr_count    = 0;
			skip_left    = '0;
			errors       = 0;
			foreach (hdr[i]) hdr[i] = '0;
		endfunction

		function void write_reg(logic idx, logic [31:0] data);
			if (idx == REG_SYNC) begin
				sync_pattern = data[7:0];
			end else begin
				ident = data[10:0];
			end
		endfunction

		function int unsigned pending();
			return frames_due.size();
		endfunction

		// Advances the parser by one accepted byte transaction.
		function void note_byte(logic [7:0] b);
			result_t r;
			case (mode)
				MODE_COLLECT: begin
					if (hdr_count < STORE_DEPTH) begin
						hdr[hdr_count] = b;
						hdr_count++;
					end else begin
						r.payload      = {16'h0000, b, hdr[4], hdr[3], hdr[2], hdr[1], hdr[0]};
						r.ident_out    = ident;
						r.sequence_res = hdr[1];
						r.length_field = {hdr[3], hdr[2]};
						r.opcode_field = {b, hdr[4]};
						r.skip_count   = (r.length_field >= 16'd2) ? r.length_field - 16'd2 : 16'd0;
						frames_due.push_back(r);
						hdr_count = 0;
						skip_left = r.skip_count;
						mode      = (r.skip_count != 0) ? MODE_DISCARD : MODE_HUNT;
					end
				end
				MODE_DISCARD: begin
					if (skip_left != 0) skip_left--;
					if (skip_left == 0) mode = MODE_HUNT;
				end
				default: begin
					// Hunting: only the sync byte opens a frame.
					mode = MODE_HUNT;
					if (b == sync_pattern) begin
						hdr[0]    = b;
						hdr_count = 1;
						mode      = MODE_COLLECT;
					end
				end
			endcase
		endfunction

		function void check_field(string fname, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, fname, want, got);
			end
		endfunction

		// Compares one result transaction with the oldest prediction.
		function void check_frame(result_t got);
			result_t want;
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual payload 0x%0h",
					$time, got.payload);
				return;
			end
			want = frames_due.pop_front();
			check_field("payload", want.payload, got.payload);
			check_field("ident_out", want.ident_out, got.ident_out);
			check_field("sequence_res", want.sequence_res, got.sequence_res);
			check_field("length_field", want.length_field, got.length_field);
			check_field("opcode_field", want.opcode_field, got.opcode_field);
			check_field("skip_count", want.skip_count, got.skip_count);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic [7:0]  rx_byte   = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [63:0] payload;
	logic [10:0] ident_out;
	logic [7:0]  sequence_res;
	logic [15:0] length_field;
	logic [15:0] opcode_field;
	logic [15:0] skip_count;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	bit          tx_steady  = 1'b0;
	bit          rx_steady  = 1'b0;
	int unsigned rx_hold    = 0;
	int unsigned cycle_count = 0;

	frame_header_scoreboard sb = new();

	sync_length_header_framer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload      (payload),
		.ident_out    (ident_out),
		.sequence_res (sequence_res),
		.length_field (length_field),
		.opcode_field (opcode_field),
		.skip_count   (skip_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Observes both channels at the rising edge.
	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_byte(rx_byte);
			if (out_valid && out_ready) begin
				got.payload      = payload;
				got.ident_out    = ident_out;
				got.sequence_res = sequence_res;
				got.length_field = length_field;
				got.opcode_field = opcode_field;
				got.skip_count   = skip_count;
				sb.check_frame(got);
			end
		end
	end

	// Result receiver: random stalls, or a counted hold-off when requested.
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold = rx_hold - 1;
			end else begin
				out_ready <= rx_steady || ($urandom_range(99) >= 7);
			end
		end
	end

	// Offers one byte and returns at the falling edge after its transaction.
	task automatic send_byte(input logic [7:0] b);
		while (!tx_steady && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] seq_byte, input logic [15:0] len,
			input logic [15:0] op);
		send_byte(sb.sync_pattern);
		send_byte(seq_byte);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(op[7:0]);
		send_byte(op[15:8]);
	endtask

	// Trailer bytes, with the sync value mixed in as ordinary data.
	task automatic send_trailer(input int unsigned count);
		logic [7:0] b;
		repeat (count) begin
			b = ($urandom_range(7) == 0) ? sb.sync_pattern : 8'($urandom);
			send_byte(b);
		end
	endtask

	// Bytes that cannot open a frame while hunting.
	task automatic send_noise(input int unsigned count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom);
			if (b == sb.sync_pattern) b = ~b;
			send_byte(b);
		end
	endtask

	// Stops the sender until every predicted result has arrived and the pipeline is empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Writes both registers with random junk above the field widths.
	task automatic configure(input logic [7:0] s, input logic [10:0] id);
		logic [31:0] data;
		data = $urandom;
		data[7:0] = s;
		apb_write(REG_SYNC, data);
		data = $urandom;
		data[10:0] = id;
		apb_write(REG_IDENT, data);
	endtask

	function automatic logic [15:0] pick_length();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 60) return 16'($urandom_range(8));
		if (p < 90) return 16'($urandom_range(40, 9));
		return 16'($urandom_range(120, 41));
	endfunction

	// One random frame, sometimes preceded by noise or a broken sequence.
	task automatic random_frame();
		int unsigned p;
		logic [15:0] len;
		p = $urandom_range(99);
		if (p < 8) begin
			repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
		end else if (p < 20) begin
			send_noise($urandom_range(4, 1));
		end
		len = pick_length();
		send_frame(8'($urandom), len, 16'($urandom));
		send_trailer((len >= 16'd2) ? len - 16'd2 : 0);
	endtask

	initial begin
		logic [7:0]  s;
		logic [10:0] id;
		logic [15:0] len;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: ignored bytes, then header extremes under reset settings.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'h00, 16'h0000, 16'h0000);
		send_frame(8'hFF, 16'h0001, 16'hFFFF);
		// Sync value inside the header and inside the trailer is plain data.
		send_frame(SYNC_RESET, 16'h0004, {SYNC_RESET, SYNC_RESET});
		send_byte(SYNC_RESET);
		send_byte(SYNC_RESET);
		// Registers change while a header is half collected.
		send_byte(SYNC_RESET);
		send_byte(8'h5A);
		wait_idle();
		configure(8'h3C, 11'h000);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h34);
		send_byte(8'h12);
		wait_idle();

		// Random phases, each under its own register setting.
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin s = 8'hFF; id = 11'h7FF; end
				1: begin s = 8'h00; id = 11'h555; end
				5: begin s = SYNC_RESET; id = IDENT_RESET; end
				default: begin s = 8'($urandom); id = 11'($urandom); end
			endcase
			configure(s, id);

			if (phase == 1) begin
				// Long receiver hold-off against back-to-back short frames.
				rx_hold   = 400;
				tx_steady = 1'b1;
				repeat (20) begin
					len = 16'($urandom_range(2));
					send_frame(8'($urandom), len, 16'($urandom));
				end
				tx_steady = 1'b0;
			end
			if (phase == 2) begin
				tx_steady = 1'b1;
				rx_steady = 1'b1;
			end

			repeat (PHASE_FRAMES) random_frame();

			if (phase == PHASES - 1) begin
				// Largest length last; only the start of its trailer is sent.
				send_frame(8'($urandom), 16'hFFFF, 16'($urandom));
				send_trailer(8);
			end

			tx_steady = 1'b0;
			rx_steady = 1'b0;
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/slhf_pkg.sv
rtl/slhf_cfg.sv
rtl/slhf_parse.sv
rtl/slhf_outreg.sv
rtl/sync_length_header_framer_unit.sv
tb/sv/tb_top.sv
